>>> src/lwm_pkg.sv
// lwm_pkg: shared widths, codes, table entry types and helpers for the
// low-water-mark type open list. Depends on nothing.
package lwm_pkg;

	localparam int ID_W         = 16;
	localparam int KEY_W        = 17;
	localparam int H_W          = 16;
	localparam int RAND_W       = 16;
	localparam int N_BUCKETS    = 256;
	localparam int BUCKET_DEPTH = 256;
	localparam int N_STATES     = 65536;
	localparam int BKT_W        = $clog2(N_BUCKETS);
	localparam int POS_W        = $clog2(BUCKET_DEPTH);
	localparam int CNT_W        = BKT_W + 1;
	localparam int SLOT_DEPTH   = N_STATES + 1;
	localparam int SLOT_AW      = $clog2(SLOT_DEPTH);
	localparam int ENT_AW       = BKT_W + POS_W;

	localparam logic [H_W-1:0]   H_INF    = '1;
	localparam logic [KEY_W-1:0] NULL_KEY = KEY_W'(N_STATES);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_REMOVED  = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_DROPPED  = 3'd3;
	localparam logic [2:0] ST_CLEARED  = 3'd4;

	typedef struct packed {
		logic [H_W-1:0]   h;
		logic [KEY_W-1:0] key;
	} type_ent_t;

	typedef struct packed {
		logic             valid;
		logic [BKT_W-1:0] slot;
	} slot_ent_t;

	// owner key, fill and physical block of one bucket
	typedef struct packed {
		logic [KEY_W-1:0] owner;
		logic [CNT_W-1:0] fill;
		logic [BKT_W-1:0] blk;
	} bkt_ent_t;

	// null key maps to the extra last slot entry
	function automatic logic [SLOT_AW-1:0] key_index(input logic [KEY_W-1:0] key);
		logic [SLOT_AW-1:0] r;
		if (key >= NULL_KEY) r = SLOT_AW'(N_STATES);
		else r = SLOT_AW'(key[ID_W-1:0]);
		return r;
	endfunction

endpackage

>>> src/lwm_ram.sv
// lwm_ram: generic simple dual-port ram, one write and one registered read.
// No dependencies.
module lwm_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> src/lwm_mul.sv
// lwm_mul: shared multiply-high unit, scales a random draw to a range.
// Depends on lwm_pkg.
module lwm_mul (
	input  logic                       clk,
	input  logic [lwm_pkg::RAND_W-1:0] a,
	input  logic [lwm_pkg::CNT_W-1:0]  b,
	output logic [lwm_pkg::CNT_W-1:0]  hi_q
);
	logic [lwm_pkg::RAND_W+lwm_pkg::CNT_W-1:0] prod;

	assign prod = (lwm_pkg::RAND_W + lwm_pkg::CNT_W)'(a) * (lwm_pkg::RAND_W + lwm_pkg::CNT_W)'(b);

	always_ff @(posedge clk) begin
		hi_q <= prod[lwm_pkg::RAND_W+lwm_pkg::CNT_W-1:lwm_pkg::RAND_W];
	end
endmodule

>>> src/low_water_mark_type_open_list_unit.sv
// low_water_mark_type_open_list_unit: top level, sequencer around the type,
// slot, bucket and entry rams and the shared multiply-high unit.
// Depends on lwm_pkg, lwm_ram, lwm_mul.
//
// Open list of search states grouped by low-water-mark type. A beat is taken
// when start is high and busy low; its one result beat appears later on the
// result ports with done high for exactly one cycle and cannot be held off.
// After reset the block sweeps the key slot table with busy high before it
// takes the first beat. A remove runs through a chain of dependent ram reads
// through the bucket table and entry store, and the two scalings in the one
// multiplier. An insert is dropped when the bucket table is full or when its
// bucket is full. A remove or clear on an empty list is answered straight from
// idle, and a clear reads each bucket row and does one slot write per bucket.
// busy drops in the cycle done is shown, so a new beat can start there.
module low_water_mark_type_open_list_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [15:0] state_id,
	input  logic [15:0] parent_id,
	input  logic        parent_is_root,
	input  logic [15:0] h_value,
	input  logic [15:0] random_bucket,
	input  logic [15:0] random_entry,
	output logic        done,
	output logic [2:0]  status,
	output logic [15:0] removed_state,
	output logic [16:0] group_key,
	output logic [15:0] type_h,
	output logic        list_empty,
	output logic [8:0]  bucket_total
);
	typedef enum logic [3:0] {
		S_INIT, S_IDLE,
		S_INS_PAR, S_INS_TYPE, S_INS_SLOT, S_INS_PUT,
		S_REM_MUL, S_REM_BKT, S_REM_POS, S_REM_GET, S_REM_LAST, S_REM_FIX, S_REM_SWAP,
		S_CLR_RD, S_CLR_WR
	} state_t;

	state_t state_q;

	// latched beat
	logic [lwm_pkg::ID_W-1:0]          id_q, pid_q;
	logic                              root_q;
	logic [lwm_pkg::H_W-1:0]           h_q;
	logic [lwm_pkg::RAND_W-1:0]        rb_q, re_q;

	// working registers
	logic [lwm_pkg::SLOT_AW-1:0]       cnt_q;
	logic [lwm_pkg::CNT_W-1:0]         live_q;
	logic [lwm_pkg::BKT_W-1:0]         b_q, idx_q;
	logic [lwm_pkg::POS_W-1:0]         pos_q;
	logic                              new_q;
	logic [lwm_pkg::H_W-1:0]           th_q;
	logic [lwm_pkg::KEY_W-1:0]         tk_q;
	lwm_pkg::bkt_ent_t                 bkt_q;
	logic [lwm_pkg::ID_W-1:0]          got_q;

	// result registers
	logic                              done_q;
	logic [2:0]                        status_q;
	logic [lwm_pkg::ID_W-1:0]          removed_q;
	logic [lwm_pkg::KEY_W-1:0]         key_q;
	logic [lwm_pkg::H_W-1:0]           rh_q;

	// ram ports
	logic                              ty_we;
	logic [lwm_pkg::ID_W-1:0]          ty_wa, ty_ra;
	lwm_pkg::type_ent_t                ty_wd, ty_rd;
	logic                              sl_we;
	logic [lwm_pkg::SLOT_AW-1:0]       sl_wa, sl_ra;
	lwm_pkg::slot_ent_t                sl_wd, sl_rd;
	logic                              bt_we;
	logic [lwm_pkg::BKT_W-1:0]         bt_wa, bt_ra;
	lwm_pkg::bkt_ent_t                 bt_wd, bt_rd;
	logic                              en_we;
	logic [lwm_pkg::ENT_AW-1:0]        en_wa, en_ra;
	logic [lwm_pkg::ID_W-1:0]          en_wd, en_rd;

	// shared multiplier
	logic [lwm_pkg::RAND_W-1:0]        mul_a;
	logic [lwm_pkg::CNT_W-1:0]         mul_b, mul_q;

	// type chosen for the inserted state
	logic [lwm_pkg::H_W-1:0]           ph, th;
	logic [lwm_pkg::KEY_W-1:0]         pk, tk;
	logic [lwm_pkg::CNT_W-1:0]         fill_dec, live_dec;
	logic                              accept;

	assign accept   = start && (state_q == S_IDLE);
	assign fill_dec = lwm_pkg::CNT_W'(bkt_q.fill - 1'b1);
	assign live_dec = lwm_pkg::CNT_W'(live_q - 1'b1);

	always_comb begin
		ph = root_q ? lwm_pkg::H_INF : ty_rd.h;
		pk = root_q ? lwm_pkg::NULL_KEY : ty_rd.key;
		if (h_q < ph) begin
			th = h_q;
			tk = lwm_pkg::KEY_W'(id_q);
		end else begin
			th = ph;
			tk = pk;
		end
	end

	lwm_ram #(.W($bits(lwm_pkg::type_ent_t)), .D(lwm_pkg::N_STATES)) u_type_ram (
		.clk(clk), .we(ty_we), .waddr(ty_wa), .wdata(ty_wd), .raddr(ty_ra), .rdata(ty_rd)
	);

	lwm_ram #(.W($bits(lwm_pkg::slot_ent_t)), .D(lwm_pkg::SLOT_DEPTH)) u_slot_ram (
		.clk(clk), .we(sl_we), .waddr(sl_wa), .wdata(sl_wd), .raddr(sl_ra), .rdata(sl_rd)
	);

	lwm_ram #(.W($bits(lwm_pkg::bkt_ent_t)), .D(lwm_pkg::N_BUCKETS)) u_bkt_ram (
		.clk(clk), .we(bt_we), .waddr(bt_wa), .wdata(bt_wd), .raddr(bt_ra), .rdata(bt_rd)
	);

	lwm_ram #(.W(lwm_pkg::ID_W), .D(lwm_pkg::N_BUCKETS * lwm_pkg::BUCKET_DEPTH)) u_ent_ram (
		.clk(clk), .we(en_we), .waddr(en_wa), .wdata(en_wd), .raddr(en_ra), .rdata(en_rd)
	);

	lwm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .hi_q(mul_q));

	// ram and multiplier control per sequencer step
	always_comb begin
		ty_we = 1'b0; ty_wa = id_q;  ty_wd = '{h: th, key: tk}; ty_ra = pid_q;
		sl_we = 1'b0; sl_wa = '0;    sl_wd = '0;  sl_ra = lwm_pkg::key_index(tk_q);
		bt_we = 1'b0; bt_wa = b_q;   bt_wd = bkt_q; bt_ra = b_q;
		en_we = 1'b0; en_wa = '0;    en_wd = id_q;  en_ra = '0;
		mul_a = rb_q; mul_b = live_q;
		case (state_q)
			S_INIT: begin
				// invalidate every slot; every row of the bucket table gets
				// the identity block map
				sl_we = 1'b1;
				sl_wa = cnt_q;
				if (cnt_q < lwm_pkg::SLOT_AW'(lwm_pkg::N_BUCKETS)) begin
					bt_we = 1'b1;
					bt_wa = cnt_q[lwm_pkg::BKT_W-1:0];
					bt_wd = '{owner: '0, fill: '0, blk: cnt_q[lwm_pkg::BKT_W-1:0]};
				end
			end
			S_INS_TYPE: begin
				ty_we = 1'b1;
				sl_ra = lwm_pkg::key_index(tk);
			end
			S_INS_SLOT: begin
				bt_ra = sl_rd.valid ? sl_rd.slot : live_q[lwm_pkg::BKT_W-1:0];
			end
			S_INS_PUT: begin
				if (new_q || bt_rd.fill < lwm_pkg::CNT_W'(lwm_pkg::BUCKET_DEPTH)) begin
					en_we = 1'b1;
					en_wa = {bt_rd.blk,
					         new_q ? lwm_pkg::POS_W'(0) : bt_rd.fill[lwm_pkg::POS_W-1:0]};
					bt_we = 1'b1;
					if (new_q) begin
						bt_wd = '{owner: tk_q, fill: lwm_pkg::CNT_W'(1), blk: bt_rd.blk};
						sl_we = 1'b1;
						sl_wa = lwm_pkg::key_index(tk_q);
						sl_wd = '{valid: 1'b1, slot: b_q};
					end else begin
						bt_wd = '{owner: bt_rd.owner,
						          fill: lwm_pkg::CNT_W'(bt_rd.fill + 1'b1), blk: bt_rd.blk};
					end
				end
			end
			S_REM_BKT: begin
				bt_ra = mul_q[lwm_pkg::BKT_W-1:0];
			end
			S_REM_POS: begin
				mul_a = re_q;
				mul_b = bt_rd.fill;
			end
			S_REM_GET: begin
				en_ra = {bkt_q.blk, mul_q[lwm_pkg::POS_W-1:0]};
			end
			S_REM_LAST: begin
				en_ra = {bkt_q.blk, fill_dec[lwm_pkg::POS_W-1:0]};
				bt_ra = live_dec[lwm_pkg::BKT_W-1:0];
			end
			S_REM_FIX: begin
				// move the last entry into the hole
				en_we = 1'b1;
				en_wa = {bkt_q.blk, pos_q};
				en_wd = en_rd;
				bt_we = 1'b1;
				if (fill_dec != '0) begin
					bt_wd = '{owner: bkt_q.owner, fill: fill_dec, blk: bkt_q.blk};
				end else begin
					// bucket empty: last bucket takes its place
					bt_wd = bt_rd;
					sl_we = 1'b1;
					sl_wa = lwm_pkg::key_index(bt_rd.owner);
					sl_wd = '{valid: 1'b1, slot: b_q};
				end
			end
			S_REM_SWAP: begin
				sl_we = 1'b1;
				sl_wa = lwm_pkg::key_index(bkt_q.owner);
				sl_wd = '0;
				// freed block goes to the row that becomes free
				bt_we = 1'b1;
				bt_wa = live_dec[lwm_pkg::BKT_W-1:0];
				bt_wd = '{owner: bkt_q.owner, fill: '0, blk: bkt_q.blk};
			end
			S_CLR_RD: begin
				bt_ra = idx_q;
			end
			S_CLR_WR: begin
				sl_we = 1'b1;
				sl_wa = lwm_pkg::key_index(bt_rd.owner);
				sl_wd = '0;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q   <= '0;
			live_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					cnt_q <= lwm_pkg::SLOT_AW'(cnt_q + 1'b1);
					if (cnt_q == lwm_pkg::SLOT_AW'(lwm_pkg::SLOT_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						id_q   <= state_id;
						pid_q  <= parent_id;
						root_q <= parent_is_root;
						h_q    <= h_value;
						rb_q   <= random_bucket;
						re_q   <= random_entry;
						idx_q  <= '0;
						if (operation == lwm_pkg::OP_INSERT) begin
							state_q <= S_INS_PAR;
						end else if (live_q == '0) begin
							// nothing to remove or clear
							done_q    <= 1'b1;
							status_q  <= (operation == lwm_pkg::OP_REMOVE) ?
							             lwm_pkg::ST_EMPTY : lwm_pkg::ST_CLEARED;
							removed_q <= '0;
							key_q     <= '0;
							rh_q      <= '0;
						end else if (operation == lwm_pkg::OP_REMOVE) begin
							state_q <= S_REM_MUL;
						end else begin
							state_q <= S_CLR_RD;
						end
					end
				end
				S_INS_PAR: state_q <= S_INS_TYPE;
				S_INS_TYPE: begin
					th_q    <= th;
					tk_q    <= tk;
					state_q <= S_INS_SLOT;
				end
				S_INS_SLOT: begin
					if (sl_rd.valid) begin
						b_q     <= sl_rd.slot;
						new_q   <= 1'b0;
						state_q <= S_INS_PUT;
					end else if (live_q >= lwm_pkg::CNT_W'(lwm_pkg::N_BUCKETS)) begin
						done_q    <= 1'b1;
						status_q  <= lwm_pkg::ST_DROPPED;
						removed_q <= '0;
						key_q     <= tk_q;
						rh_q      <= th_q;
						state_q   <= S_IDLE;
					end else begin
						b_q     <= live_q[lwm_pkg::BKT_W-1:0];
						new_q   <= 1'b1;
						state_q <= S_INS_PUT;
					end
				end
				S_INS_PUT: begin
					done_q    <= 1'b1;
					removed_q <= '0;
					key_q     <= tk_q;
					rh_q      <= th_q;
					state_q   <= S_IDLE;
					if (new_q) begin
						live_q   <= lwm_pkg::CNT_W'(live_q + 1'b1);
						status_q <= lwm_pkg::ST_INSERTED;
					end else if (bt_rd.fill < lwm_pkg::CNT_W'(lwm_pkg::BUCKET_DEPTH)) begin
						status_q <= lwm_pkg::ST_INSERTED;
					end else begin
						status_q <= lwm_pkg::ST_DROPPED;
					end
				end
				S_REM_MUL: state_q <= S_REM_BKT;
				S_REM_BKT: begin
					b_q     <= mul_q[lwm_pkg::BKT_W-1:0];
					state_q <= S_REM_POS;
				end
				S_REM_POS: begin
					bkt_q <= bt_rd;
					if (bt_rd.fill == '0 ||
					    bt_rd.fill > lwm_pkg::CNT_W'(lwm_pkg::BUCKET_DEPTH)) begin
						done_q    <= 1'b1;
						status_q  <= lwm_pkg::ST_EMPTY;
						removed_q <= '0;
						key_q     <= '0;
						rh_q      <= '0;
						state_q   <= S_IDLE;
					end else begin
						state_q <= S_REM_GET;
					end
				end
				S_REM_GET: begin
					pos_q   <= mul_q[lwm_pkg::POS_W-1:0];
					state_q <= S_REM_LAST;
				end
				S_REM_LAST: begin
					got_q   <= en_rd;
					state_q <= S_REM_FIX;
				end
				S_REM_FIX: begin
					if (fill_dec != '0) begin
						done_q    <= 1'b1;
						status_q  <= lwm_pkg::ST_REMOVED;
						removed_q <= got_q;
						key_q     <= '0;
						rh_q      <= '0;
						state_q   <= S_IDLE;
					end else begin
						state_q <= S_REM_SWAP;
					end
				end
				S_REM_SWAP: begin
					live_q    <= live_dec;
					done_q    <= 1'b1;
					status_q  <= lwm_pkg::ST_REMOVED;
					removed_q <= got_q;
					key_q     <= '0;
					rh_q      <= '0;
					state_q   <= S_IDLE;
				end
				S_CLR_RD: state_q <= S_CLR_WR;
				S_CLR_WR: begin
					idx_q <= lwm_pkg::BKT_W'(idx_q + 1'b1);
					if (lwm_pkg::CNT_W'(idx_q) == live_dec) begin
						live_q    <= '0;
						done_q    <= 1'b1;
						status_q  <= lwm_pkg::ST_CLEARED;
						removed_q <= '0;
						key_q     <= '0;
						rh_q      <= '0;
						state_q   <= S_IDLE;
					end else begin
						state_q <= S_CLR_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign removed_state = removed_q;
	assign group_key     = key_q;
	assign type_h        = rh_q;
	// live count already reflects the finished beat in the done cycle
	assign bucket_total  = live_q;
	assign list_empty    = (live_q == '0);

`ifndef ASSERT_OFF
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= lwm_pkg::CNT_W'(lwm_pkg::N_BUCKETS))
		else $error("bucket count above table size");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result beat while sequencer busy");

	a_empty_remove: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == lwm_pkg::OP_REMOVE && live_q == '0)
		|=> (done_q && status_q == lwm_pkg::ST_EMPTY))
		else $error("remove on empty list not answered at once");

	a_removed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != lwm_pkg::ST_REMOVED) |-> (removed_q == '0))
		else $error("removed state set on a non-remove beat");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == lwm_pkg::ST_CLEARED) |-> (live_q == '0))
		else $error("clear left buckets behind");
`endif
endmodule
